// File: hdl/mpa_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mpa_pkg
// Shared constants, codes and controller/datapath interface types for the
// memory placement allocator.
// ----------------------------------------------------------------------------
package mpa_pkg;

    // Table geometry.
    localparam int MAX_BLOCKS = 16;
    localparam int SIZE_W     = 16;
    localparam int IDX_W      = $clog2(MAX_BLOCKS);
    localparam int COUNT_W    = $clog2(MAX_BLOCKS + 1);

    // Item field widths.
    localparam int OPCODE_W  = 1;
    localparam int STATUS_W  = 2;
    localparam int MODE_W    = 2;
    localparam int BLOCKS_W  = 5;
    localparam int CFG_IDX_W = 1;
    localparam int CFG_DAT_W = 5;
    localparam int S_DATA_W  = 24;
    localparam int M_DATA_W  = 24;

    // Opcodes.
    localparam logic [OPCODE_W-1:0] OP_LOAD  = 1'b0;
    localparam logic [OPCODE_W-1:0] OP_ALLOC = 1'b1;

    // Result status codes.
    localparam logic [STATUS_W-1:0] ST_LOADED = 2'd0;
    localparam logic [STATUS_W-1:0] ST_ALLOC  = 2'd1;
    localparam logic [STATUS_W-1:0] ST_NOFIT  = 2'd2;

    // Placement strategies.
    localparam logic [MODE_W-1:0] MODE_FIRST = 2'd0;
    localparam logic [MODE_W-1:0] MODE_NEXT  = 2'd1;
    localparam logic [MODE_W-1:0] MODE_BEST  = 2'd2;
    localparam logic [MODE_W-1:0] MODE_WORST = 2'd3;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] REG_STRATEGY = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_BLOCKS   = 1'b1;

    // Controller to datapath commands.
    typedef struct packed {
        logic capture;
        logic scan;
        logic commit;
    } mpa_cmd_t;

    // Datapath to controller status.
    typedef struct packed {
        logic is_alloc;
        logic scan_done;
        logic out_free;
    } mpa_stat_t;

endpackage
`default_nettype wire

// File: hdl/mpa_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mpa_ctrl
// Controller state machine: takes an item, steps the table scan and hands
// the finished result to the output register.
// ----------------------------------------------------------------------------
module mpa_ctrl
    import mpa_pkg::*;
(
    input  wire logic      aclk,
    input  wire logic      aresetn,
    input  wire logic      s_tvalid,
    output logic           s_tready,
    input  wire mpa_stat_t stat,
    output mpa_cmd_t       cmd
);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_SCAN = 2'd1;
    localparam logic [1:0] S_FIN  = 2'd2;

    logic [1:0] state_reg;
    logic [1:0] state_next;

    // Next-state and command decode.
    always_comb begin
        state_next  = state_reg;
        cmd.capture = 1'b0;
        cmd.scan    = 1'b0;
        cmd.commit  = 1'b0;
        s_tready    = 1'b0;
        case (state_reg)
            S_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    cmd.capture = 1'b1;
                    state_next  = stat.is_alloc ? S_SCAN : S_FIN;
                end
            end
            S_SCAN: begin
                cmd.scan = 1'b1;
                if (stat.scan_done) begin
                    state_next = S_FIN;
                end
            end
            S_FIN: begin
                if (stat.out_free) begin
                    cmd.commit = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    // State register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

endmodule
`default_nettype wire

// File: hdl/mpa_datapath.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mpa_datapath
// Size table, scan pointer, candidate tracking and the output register.
// ----------------------------------------------------------------------------
module mpa_datapath
    import mpa_pkg::*;
(
    input  wire logic                aclk,
    input  wire logic                aresetn,
    input  wire mpa_cmd_t            cmd,
    output mpa_stat_t                stat,
    input  wire logic [MODE_W-1:0]   strategy_mode,
    input  wire logic [BLOCKS_W-1:0] blocks_in_use,
    input  wire logic [OPCODE_W-1:0] in_opcode,
    input  wire logic [IDX_W-1:0]    in_index,
    input  wire logic [SIZE_W-1:0]   in_size,
    output logic                     out_valid,
    input  wire logic                out_ready,
    output logic [STATUS_W-1:0]      out_status,
    output logic [IDX_W-1:0]         out_block,
    output logic [SIZE_W-1:0]        out_rem
);

    logic [SIZE_W-1:0]   blk_mem [MAX_BLOCKS];
    logic [OPCODE_W-1:0] op_reg;
    logic [IDX_W-1:0]    idx_reg;
    logic [SIZE_W-1:0]   req_reg;
    logic [IDX_W-1:0]    pos_reg;
    logic [SIZE_W-1:0]   cur_val_reg;
    logic [COUNT_W-1:0]  cnt_reg;
    logic                found_reg;
    logic [IDX_W-1:0]    pick_reg;
    logic [SIZE_W-1:0]   pick_val_reg;
    logic [IDX_W-1:0]    ptr_reg;
    logic                out_valid_reg;
    logic [STATUS_W-1:0] out_status_reg;
    logic [IDX_W-1:0]    out_block_reg;
    logic [SIZE_W-1:0]   out_rem_reg;

    logic [COUNT_W-1:0] n_active;
    logic               fits;
    logic               stop_first;
    logic               take;
    logic [COUNT_W-1:0] pos_inc;
    logic [IDX_W-1:0]   pos_next;
    logic [IDX_W-1:0]   pos_start;
    logic [SIZE_W-1:0]  new_rem;

    // Searched block count, saturated to the table depth.
    assign n_active = (blocks_in_use > BLOCKS_W'(MAX_BLOCKS)) ? COUNT_W'(MAX_BLOCKS)
                                                               : COUNT_W'(blocks_in_use);

    // Compare the entry under the scan pointer with the request. The entry is
    // read together with the pointer, so during a scan cur_val_reg matches pos_reg.
    assign fits       = (cur_val_reg >= req_reg);
    assign stop_first = (strategy_mode == MODE_FIRST) || (strategy_mode == MODE_NEXT);
    assign take       = fits && (!found_reg ||
                        ((strategy_mode == MODE_BEST)  && (cur_val_reg < pick_val_reg)) ||
                        ((strategy_mode == MODE_WORST) && (cur_val_reg > pick_val_reg)));
    assign pos_inc    = COUNT_W'(pos_reg) + COUNT_W'(1);
    assign pos_next   = (pos_inc == n_active) ? '0 : pos_inc[IDX_W-1:0];

    // Next fit resumes at the kept pointer when it lies inside the searched range.
    assign pos_start = ((strategy_mode == MODE_NEXT) && (COUNT_W'(ptr_reg) < n_active))
                       ? ptr_reg : '0;

    assign new_rem = pick_val_reg - req_reg;

    // Status towards the controller.
    assign stat.is_alloc  = (in_opcode == OP_ALLOC);
    assign stat.scan_done = (n_active == '0) || (fits && stop_first) ||
                            ((cnt_reg + COUNT_W'(1)) == n_active);
    assign stat.out_free  = !out_valid_reg || out_ready;

    // Item capture and scan registers.
    always_ff @(posedge aclk) begin
        if (cmd.capture) begin
            op_reg      <= in_opcode;
            idx_reg     <= in_index;
            req_reg     <= in_size;
            pos_reg     <= pos_start;
            cur_val_reg <= blk_mem[pos_start];
            cnt_reg     <= '0;
            found_reg   <= 1'b0;
        end else if (cmd.scan && (n_active != '0)) begin
            if (take) begin
                found_reg    <= 1'b1;
                pick_reg     <= pos_reg;
                pick_val_reg <= cur_val_reg;
            end
            cnt_reg     <= cnt_reg + COUNT_W'(1);
            pos_reg     <= pos_next;
            cur_val_reg <= blk_mem[pos_next];
        end
    end

    // Table writes: a load stores the size, a grant stores what is left.
    always_ff @(posedge aclk) begin
        if (cmd.commit) begin
            if (op_reg == OP_LOAD) begin
                if (COUNT_W'(idx_reg) < COUNT_W'(MAX_BLOCKS)) begin
                    blk_mem[idx_reg] <= req_reg;
                end
            end else if (found_reg) begin
                blk_mem[pick_reg] <= new_rem;
            end
        end
    end

    // Next-fit pointer stays on the last granted block.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ptr_reg <= '0;
        end else if (cmd.commit && (op_reg == OP_ALLOC) && found_reg &&
                     (strategy_mode == MODE_NEXT)) begin
            ptr_reg <= pick_reg;
        end
    end

    // Output register: holds a result until the consumer takes it.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (cmd.commit) begin
            out_valid_reg <= 1'b1;
        end else if (out_ready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.commit) begin
            if (op_reg == OP_LOAD) begin
                out_status_reg <= ST_LOADED;
                out_block_reg  <= idx_reg;
                out_rem_reg    <= (COUNT_W'(idx_reg) < COUNT_W'(MAX_BLOCKS)) ? req_reg : '0;
            end else if (found_reg) begin
                out_status_reg <= ST_ALLOC;
                out_block_reg  <= pick_reg;
                out_rem_reg    <= new_rem;
            end else begin
                out_status_reg <= ST_NOFIT;
                out_block_reg  <= '0;
                out_rem_reg    <= '0;
            end
        end
    end

    assign out_valid  = out_valid_reg;
    assign out_status = out_status_reg;
    assign out_block  = out_block_reg;
    assign out_rem    = out_rem_reg;

endmodule
`default_nettype wire

// File: hdl/memory_placement_allocator_core.sv
`timescale 1ns / 1ps
`default_nettype none
// Sequence: an accepted load goes straight to the finish state; an allocate
// first scans the entries one per cycle (up to blocks_in_use, at most 16; all of
// them for best and worst fit). The result is committed once the output is free.
// A new item is only taken after the previous result has been committed.
// Reset: controller idle, output empty, next-fit pointer 0, strategy first fit,
// 16 blocks in use; the size table holds no reset value and must be loaded.
// ----------------------------------------------------------------------------
// memory_placement_allocator_core
// First, next, best and worst fit block allocator over a table of free sizes.
// ----------------------------------------------------------------------------
module memory_placement_allocator_core
    import mpa_pkg::*;
(
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    // Item input.
    input  wire logic                 s_tvalid,
    output logic                      s_tready,
    input  wire logic [S_DATA_W-1:0]  s_tdata,  // load_index[3:0], size_value[19:4], zeros
    input  wire logic [OPCODE_W-1:0]  s_tuser,  // opcode[0]
    // Result output.
    output logic                      m_tvalid,
    input  wire logic                 m_tready,
    output logic [M_DATA_W-1:0]       m_tdata,  // block_number[3:0], remaining_size[19:4], zeros
    output logic [STATUS_W-1:0]       m_tuser,  // status[1:0]
    // Configuration writes.
    input  wire logic                 cfg_valid,
    output logic                      cfg_ready,
    input  wire logic [CFG_IDX_W-1:0] cfg_index,
    input  wire logic [CFG_DAT_W-1:0] cfg_data
);

    logic [MODE_W-1:0]   strategy_mode_reg;
    logic [BLOCKS_W-1:0] blocks_in_use_reg;
    mpa_cmd_t            cmd;
    mpa_stat_t           stat;
    logic [IDX_W-1:0]    out_block;
    logic [SIZE_W-1:0]   out_rem;

    // Configuration registers.
    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            strategy_mode_reg <= MODE_FIRST;
            blocks_in_use_reg <= BLOCKS_W'(MAX_BLOCKS);
        end else if (cfg_valid) begin
            case (cfg_index)
                REG_STRATEGY: strategy_mode_reg <= cfg_data[MODE_W-1:0];
                REG_BLOCKS:   blocks_in_use_reg <= cfg_data[BLOCKS_W-1:0];
                default: begin
                end
            endcase
        end
    end

    mpa_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    mpa_datapath u_datapath (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cmd           (cmd),
        .stat          (stat),
        .strategy_mode (strategy_mode_reg),
        .blocks_in_use (blocks_in_use_reg),
        .in_opcode     (s_tuser),
        .in_index      (s_tdata[IDX_W-1:0]),
        .in_size       (s_tdata[IDX_W+SIZE_W-1:IDX_W]),
        .out_valid     (m_tvalid),
        .out_ready     (m_tready),
        .out_status    (m_tuser),
        .out_block     (out_block),
        .out_rem       (out_rem)
    );

    // Output packing.
    assign m_tdata = {{(M_DATA_W - IDX_W - SIZE_W){1'b0}}, out_rem, out_block};

    // A no-fit result carries a zero block number and size.
    a_nofit_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && (m_tuser == ST_NOFIT)) |-> (m_tdata == '0))
        else $error("no-fit result with non-zero payload");

    // A granted block lies inside the searched range.
    a_grant_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && (m_tuser == ST_ALLOC)) |->
        (BLOCKS_W'(m_tdata[IDX_W-1:0]) < blocks_in_use_reg))
        else $error("granted block outside the searched range");

    // The status code is always one of the three defined results.
    a_status_code: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> ((m_tuser == ST_LOADED) || (m_tuser == ST_ALLOC) ||
                      (m_tuser == ST_NOFIT)))
        else $error("undefined result status");

    // A new item is only taken after the previous one has left the scan.
    a_accept_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready && (s_tuser == OP_ALLOC)) |=> !s_tready)
        else $error("item taken while a scan is in progress");

endmodule
`default_nettype wire

// File: tb/sv/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the memory placement allocator. A short table of
// directed items loads the whole size table and works through each strategy,
// the zero and oversized block counts and zero requests. Phases of random
// loads and allocations follow under random settings. Every result is checked
// field by field against a directed expectation or an in-bench table model.
// ----------------------------------------------------------------------------
module tb_top;
    import mpa_pkg::*;

    localparam int ITEM_TARGET = 1800;
    localparam int QUIET_ITEMS = 200;
    localparam int HOLD_CYCLES = 400;

    // One input item and one result item, as the block sees them.
    typedef struct packed {
        logic [OPCODE_W-1:0] opcode;
        logic [IDX_W-1:0]    load_index;
        logic [SIZE_W-1:0]   size_value;
    } request_t;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [IDX_W-1:0]    block_number;
        logic [SIZE_W-1:0]   remaining_size;
    } outcome_t;

    // A directed row is either an item or a register write. For a register
    // write the index field holds the register and the size field its value.
    typedef enum logic {ROW_ITEM, ROW_REG} row_kind_t;

    typedef struct packed {
        row_kind_t           kind;
        logic [OPCODE_W-1:0] opcode;
        logic [IDX_W-1:0]    index;
        logic [SIZE_W-1:0]   size;
        logic                typed;
        outcome_t            want;
    } dir_row_t;

    dir_row_t directed_rows [32] = '{
        // Fill the table; the first entry holds the largest size, the last zero.
        '{ROW_ITEM, OP_LOAD, 4'd0,  16'hFFFF, 1'b1, '{ST_LOADED, 4'd0,  16'hFFFF}},
        '{ROW_ITEM, OP_LOAD, 4'd15, 16'd0,    1'b1, '{ST_LOADED, 4'd15, 16'd0}},
        '{ROW_ITEM, OP_LOAD, 4'd1,  16'd500,  1'b0, '0},
        '{ROW_ITEM, OP_LOAD, 4'd2,  16'd300,  1'b0, '0},
        '{ROW_ITEM, OP_LOAD, 4'd3,  16'd300,  1'b0, '0},
        '{ROW_ITEM, OP_LOAD, 4'd4,  16'd1000, 1'b0, '0},
        '{ROW_ITEM, OP_LOAD, 4'd5,  16'd8000, 1'b0, '0},
        '{ROW_ITEM, OP_LOAD, 4'd6,  16'h8000, 1'b0, '0},
        '{ROW_ITEM, OP_LOAD, 4'd7,  16'd50,   1'b0, '0},
        '{ROW_ITEM, OP_LOAD, 4'd8,  16'h7FFF, 1'b0, '0},
        '{ROW_ITEM, OP_LOAD, 4'd9,  16'd1,    1'b0, '0},
        '{ROW_ITEM, OP_LOAD, 4'd10, 16'd20,   1'b0, '0},
        '{ROW_ITEM, OP_LOAD, 4'd11, 16'h5555, 1'b0, '0},
        '{ROW_ITEM, OP_LOAD, 4'd12, 16'hAAAA, 1'b0, '0},
        '{ROW_ITEM, OP_LOAD, 4'd13, 16'd300,  1'b0, '0},
        '{ROW_ITEM, OP_LOAD, 4'd14, 16'd40000, 1'b0, '0},
        // First fit: a zero request leaves the block as it is, then drain it.
        '{ROW_ITEM, OP_ALLOC, 4'd0, 16'd0,    1'b1, '{ST_ALLOC, 4'd0, 16'hFFFF}},
        '{ROW_ITEM, OP_ALLOC, 4'd0, 16'hFFFF, 1'b1, '{ST_ALLOC, 4'd0, 16'd0}},
        '{ROW_ITEM, OP_ALLOC, 4'd0, 16'hFFFF, 1'b1, '{ST_NOFIT, 4'd0, 16'd0}},
        '{ROW_ITEM, OP_ALLOC, 4'd0, 16'd300,  1'b0, '0},
        // No blocks in use: even a zero request finds nothing.
        '{ROW_REG,  OP_LOAD,  REG_BLOCKS,   16'd0,  1'b0, '0},
        '{ROW_ITEM, OP_ALLOC, 4'd0, 16'd0,    1'b1, '{ST_NOFIT, 4'd0, 16'd0}},
        // Oversized block count saturates; best fit with a three-way tie, then worst fit.
        '{ROW_REG,  OP_LOAD,  REG_BLOCKS,   16'd31, 1'b0, '0},
        '{ROW_REG,  OP_LOAD,  REG_STRATEGY, 16'(MODE_BEST),  1'b0, '0},
        '{ROW_ITEM, OP_ALLOC, 4'd0, 16'd300,  1'b0, '0},
        '{ROW_REG,  OP_LOAD,  REG_STRATEGY, 16'(MODE_WORST), 1'b0, '0},
        '{ROW_ITEM, OP_ALLOC, 4'd0, 16'd1,    1'b0, '0},
        // Next fit over a single drained block, then over the full table.
        '{ROW_REG,  OP_LOAD,  REG_STRATEGY, 16'(MODE_NEXT),  1'b0, '0},
        '{ROW_REG,  OP_LOAD,  REG_BLOCKS,   16'd1,  1'b0, '0},
        '{ROW_ITEM, OP_ALLOC, 4'd0, 16'd1,    1'b1, '{ST_NOFIT, 4'd0, 16'd0}},
        '{ROW_REG,  OP_LOAD,  REG_BLOCKS,   16'd16, 1'b0, '0},
        '{ROW_ITEM, OP_ALLOC, 4'd0, 16'd10,   1'b0, '0}
    };

    logic                 aclk = 1'b0;
    logic                 aresetn;
    logic                 s_tvalid;
    logic                 s_tready;
    logic [S_DATA_W-1:0]  s_tdata;
    logic [OPCODE_W-1:0]  s_tuser;
    logic                 m_tvalid;
    logic                 m_tready;
    logic [M_DATA_W-1:0]  m_tdata;
    logic [STATUS_W-1:0]  m_tuser;
    logic                 cfg_valid;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [CFG_DAT_W-1:0] cfg_data;

    // Model of the block: free sizes, next-fit pointer and settings.
    logic [SIZE_W-1:0]   free_size [MAX_BLOCKS];
    logic [IDX_W-1:0]    next_ptr;
    logic [MODE_W-1:0]   strategy_cfg;
    logic [BLOCKS_W-1:0] blocks_cfg;

    outcome_t expected_results [$];
    int       mismatches   = 0;
    int       results_seen = 0;
    bit       quiet        = 1'b0;
    int       gap_pct      = 0;

    memory_placement_allocator_core DUT (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always #2 aclk = ~aclk;

    // Applies one item to the table model and returns the result it gives.
    function automatic outcome_t place_request(request_t r);
        outcome_t o;
        int       n;
        int       pos;
        int       pick;
        int       j;
        o = '0;
        if (r.opcode == OP_LOAD) begin
            free_size[r.load_index] = r.size_value;
            o.status         = ST_LOADED;
            o.block_number   = r.load_index;
            o.remaining_size = r.size_value;
            return o;
        end
        n    = (blocks_cfg > MAX_BLOCKS) ? MAX_BLOCKS : int'(blocks_cfg);
        pick = -1;
        if (strategy_cfg == MODE_NEXT) begin
            // Circular scan from the kept pointer, or from block 0 if it
            // lies beyond the searched range.
            pos = (int'(next_ptr) < n) ? int'(next_ptr) : 0;
            for (j = 0; j < n; j++) begin
                if (pick < 0 && free_size[pos] >= r.size_value)
                    pick = pos;
                pos = (pos + 1 == n) ? 0 : pos + 1;
            end
        end else begin
            // Ascending scan; strict comparisons keep the lowest index on ties.
            for (j = 0; j < n; j++) begin
                if (free_size[j] >= r.size_value) begin
                    if (pick < 0 ||
                        (strategy_cfg == MODE_BEST && free_size[j] < free_size[pick]) ||
                        (strategy_cfg == MODE_WORST && free_size[j] > free_size[pick]))
                        pick = j;
                end
            end
        end
        if (pick < 0) begin
            o.status = ST_NOFIT;
            return o;
        end
        free_size[pick] = free_size[pick] - r.size_value;
        if (strategy_cfg == MODE_NEXT)
            next_ptr = IDX_W'(pick);
        o.status         = ST_ALLOC;
        o.block_number   = IDX_W'(pick);
        o.remaining_size = free_size[pick];
        return o;
    endfunction

    // Offers one item, waits for it to be taken and records its result.
    task automatic push_request(request_t r, logic typed, outcome_t typed_result);
        outcome_t predicted;
        @(negedge aclk);
        s_tvalid <= 1'b1;
        s_tuser  <= r.opcode;
        s_tdata  <= {4'b0, r.size_value, r.load_index};
        @(posedge aclk);
        while (!s_tready)
            @(posedge aclk);
        predicted = place_request(r);
        expected_results.push_back(typed ? typed_result : predicted);
    endtask

    // Writes a register once every outstanding result has come back.
    task automatic write_reg(logic [CFG_IDX_W-1:0] sel, logic [CFG_DAT_W-1:0] val);
        @(negedge aclk);
        s_tvalid <= 1'b0;
        while (expected_results.size() != 0)
            @(negedge aclk);
        @(negedge aclk);
        cfg_valid <= 1'b1;
        cfg_index <= sel;
        cfg_data  <= val;
        @(posedge aclk);
        while (!cfg_ready)
            @(posedge aclk);
        if (sel == REG_STRATEGY)
            strategy_cfg = val[MODE_W-1:0];
        else
            blocks_cfg = val[BLOCKS_W-1:0];
        @(negedge aclk);
        cfg_valid <= 1'b0;
    endtask

    // Random gap before the next item, drawn with the phase's gap_pct odds.
    task automatic pause();
        if (!quiet && $urandom_range(0, 99) < gap_pct) begin
            @(negedge aclk);
            s_tvalid <= 1'b0;
            repeat ($urandom_range(0, 8)) @(negedge aclk);
        end
    endtask

    // Stimulus: reset, the directed table, then random phases.
    initial begin
        request_t req;
        int       sent;
        int       phase_len;
        int       guard;
        logic [CFG_DAT_W-1:0] count;

        aresetn   = 1'b0;
        s_tvalid  = 1'b0;
        s_tdata   = '0;
        s_tuser   = OP_LOAD;
        cfg_valid = 1'b0;
        cfg_index = REG_STRATEGY;
        cfg_data  = '0;
        for (int k = 0; k < MAX_BLOCKS; k++)
            free_size[k] = '0;
        next_ptr     = '0;
        strategy_cfg = MODE_FIRST;
        blocks_cfg   = BLOCKS_W'(MAX_BLOCKS);
        repeat (10) @(negedge aclk);
        aresetn <= 1'b1;

        foreach (directed_rows[i]) begin
            if (directed_rows[i].kind == ROW_REG) begin
                write_reg(directed_rows[i].index[CFG_IDX_W-1:0],
                          directed_rows[i].size[CFG_DAT_W-1:0]);
            end else begin
                req.opcode     = directed_rows[i].opcode;
                req.load_index = directed_rows[i].index;
                req.size_value = directed_rows[i].size;
                push_request(req, directed_rows[i].typed, directed_rows[i].want);
            end
        end

        // Random phases, each under fresh settings.
        sent = 0;
        while (sent < ITEM_TARGET) begin
            quiet = (sent >= ITEM_TARGET - QUIET_ITEMS);
            write_reg(REG_STRATEGY, CFG_DAT_W'($urandom_range(0, 3)));
            case ($urandom_range(0, 19))
                0:       count = '0;
                1:       count = CFG_DAT_W'($urandom_range(17, 31));
                2, 3:    count = CFG_DAT_W'(1);
                4, 5, 6, 7, 8: count = CFG_DAT_W'(MAX_BLOCKS);
                default: count = CFG_DAT_W'($urandom_range(2, 15));
            endcase
            write_reg(REG_BLOCKS, count);
            case ($urandom_range(0, 2))
                0:       gap_pct = 0;
                1:       gap_pct = 10;
                default: gap_pct = 35;
            endcase
            phase_len = $urandom_range(30, 120);
            for (int k = 0; k < phase_len && sent < ITEM_TARGET; k++) begin
                req.load_index = IDX_W'($urandom_range(0, MAX_BLOCKS - 1));
                if ($urandom_range(0, 99) < 30) begin
                    req.opcode = OP_LOAD;
                    case ($urandom_range(0, 3))
                        0:       req.size_value = SIZE_W'($urandom());
                        1:       req.size_value = SIZE_W'($urandom_range(0, 2000));
                        // Copy of another entry, to make ties.
                        2:       req.size_value = free_size[$urandom_range(0, MAX_BLOCKS - 1)];
                        default: req.size_value = SIZE_W'($urandom_range(100, 600));
                    endcase
                end else begin
                    req.opcode = OP_ALLOC;
                    case ($urandom_range(0, 5))
                        0:       req.size_value = SIZE_W'($urandom());
                        1:       req.size_value = '0;
                        // Exact fit of some entry.
                        2:       req.size_value = free_size[$urandom_range(0, MAX_BLOCKS - 1)];
                        default: req.size_value = SIZE_W'($urandom_range(1, 300));
                    endcase
                end
                pause();
                push_request(req, 1'b0, '0);
                sent++;
            end
        end

        // Drain and give any stray result time to show.
        @(negedge aclk);
        s_tvalid <= 1'b0;
        for (guard = 0; expected_results.size() != 0 && guard < 100000; guard++)
            @(negedge aclk);
        repeat (40) @(negedge aclk);
        if (expected_results.size() != 0) begin
            $error("%0d results never arrived", expected_results.size());
            mismatches++;
        end
        if (mismatches == 0) begin
            $display("[memory_placement_allocator_core] OK");
        end else begin
            $display("[memory_placement_allocator_core] ERROR");
        end
        $finish;
    end

    // Result side: random stall bursts, one long hold-off, none at the end.
    initial begin
        int  stall_pct;
        int  cycles;
        bit  held;
        m_tready  = 1'b0;
        stall_pct = 0;
        cycles    = 0;
        held      = 1'b0;
        forever begin
            @(negedge aclk);
            cycles++;
            if (cycles % 97 == 0)
                stall_pct = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(5, 40);
            if (!quiet && !held && results_seen >= 300) begin
                // Hold off long enough for the block to back up its input.
                held = 1'b1;
                m_tready <= 1'b0;
                repeat (HOLD_CYCLES - 1) @(negedge aclk);
            end else if (!quiet && aresetn && $urandom_range(0, 99) < stall_pct) begin
                m_tready <= 1'b0;
                repeat ($urandom_range(0, 8)) @(negedge aclk);
            end else begin
                m_tready <= 1'b1;
            end
        end
    end

    // Compare each result item with the oldest expectation.
    always @(posedge aclk) begin : check_results
        outcome_t got;
        outcome_t want;
        if (aresetn && m_tvalid && m_tready) begin
            got.status         = m_tuser;
            got.block_number   = m_tdata[3:0];
            got.remaining_size = m_tdata[19:4];
            results_seen++;
            if (expected_results.size() == 0) begin
                $error("result with no item pending: status %0d block_number %0d",
                       got.status, got.block_number);
                mismatches++;
            end else begin
                want = expected_results.pop_front();
                if (got.status !== want.status) begin
                    $error("status: expected %0d, got %0d", want.status, got.status);
                    mismatches++;
                end
                if (got.block_number !== want.block_number) begin
                    $error("block_number: expected %0d, got %0d",
                           want.block_number, got.block_number);
                    mismatches++;
                end
                if (got.remaining_size !== want.remaining_size) begin
                    $error("remaining_size: expected %0d, got %0d",
                           want.remaining_size, got.remaining_size);
                    mismatches++;
                end
            end
        end
    end

    // Watchdog.
    initial begin
        #4_000_000;
        $display("[memory_placement_allocator_core] ERROR");
        $finish;
    end

endmodule
